// ===== hw/rtl/acrms_pkg.sv =====
// ----------------------------------------------------------------------------
// acrms_pkg
// shared widths, codes, state type and the command / status groups that join
// the controller and the datapath of the ac rms current meter
// ----------------------------------------------------------------------------
package acrms_pkg;

   // sample and register widths
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_WINDOW  = 4096;
   localparam int WIN_W       = 13;
   localparam int GAIN_W      = 16;

   // running sums
   localparam int SUM_W = 29;
   localparam int SQ_W  = 45;

   // product and divider widths
   localparam int QLO_W  = 32;
   localparam int PLO_W  = WIN_W + QLO_W;
   localparam int PHI_W  = WIN_W + SQ_W - QLO_W;
   localparam int PROD_W = WIN_W + SQ_W;
   localparam int NN_W   = 2 * WIN_W;

   // square root widths
   localparam int ROOT_W     = PROD_W / 2;
   localparam int ROOT_REM_W = ROOT_W + 2;

   // result widths
   localparam int RMS_W = 15;
   localparam int CUR_W = 25;
   localparam logic [RMS_W-1:0] RMS_MAX  = '1;
   localparam logic [9:0]       MA_PER_A = 10'd1000;

   // iteration counts of the shared divider and the root unit
   localparam int DIV_STEPS  = PROD_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int CDIV_STEPS = CUR_W;
   localparam int STEP_W     = 6;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_PER_AMP    = 4'd1;
   localparam logic [WIN_W-1:0]     WINDOW_RESET      = 13'd1024;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_VAR_LD,
      ST_VAR_DIV,
      ST_ROOT_LD,
      ST_ROOT,
      ST_SCALE,
      ST_CUR_DIV,
      ST_OUT
   } acrms_state_type;

   typedef struct packed {
      logic accum;
      logic clear;
      logic zero_out;
      logic mul_lo;
      logic mul_hi;
      logic var_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic scale_load;
      logic out_load;
   } acrms_cmd_type;

   typedef struct packed {
      logic win_zero;
      logic win_last;
      logic gain_zero;
      logic step_last;
   } acrms_status_type;

endpackage

// ===== hw/rtl/acrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// acrms_ctrl
// sequencer of the meter: takes sample words, walks the end-of-window
// computation through the datapath and owns the result word valid flag
// ----------------------------------------------------------------------------
module acrms_ctrl
   import acrms_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  acrms_status_type stat,
   output acrms_cmd_type    cmd
);

   acrms_state_type state_ff;
   acrms_state_type state_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            slot_free;
   logic            req_fire;

   // result slot can take a word this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // a zero window answers at once, so it needs the result slot
   assign req_ready = (state_ff == ST_IDLE) && (!stat.win_zero || slot_free);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !stat.win_zero && stat.win_last) state_in = ST_MUL_LO;
         end
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_VAR_LD;
         ST_VAR_LD:  state_in = ST_VAR_DIV;
         ST_VAR_DIV: begin
            if (stat.step_last) state_in = ST_ROOT_LD;
         end
         ST_ROOT_LD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (stat.step_last) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (stat.gain_zero) state_in = ST_OUT;
            else                state_in = ST_CUR_DIV;
         end
         ST_CUR_DIV: begin
            if (stat.step_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (stat.win_zero) begin
                  cmd.zero_out = 1'b1;
                  cmd.clear    = 1'b1;
               end else begin
                  cmd.accum = 1'b1;
               end
            end
         end
         ST_MUL_LO:  cmd.mul_lo     = 1'b1;
         ST_MUL_HI:  cmd.mul_hi     = 1'b1;
         ST_VAR_LD:  cmd.var_load   = 1'b1;
         ST_VAR_DIV: cmd.div_step   = 1'b1;
         ST_ROOT_LD: cmd.root_load  = 1'b1;
         ST_ROOT:    cmd.root_step  = 1'b1;
         ST_SCALE:   cmd.scale_load = 1'b1;
         ST_CUR_DIV: cmd.div_step   = 1'b1;
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   // result word valid flag
   always_comb begin
      if (cmd.zero_out || cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)               rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a pending result word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.zero_out) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   // a sample under a zero window answers in the next cycle
   a_zero_window: assert property (@(posedge clock) disable iff (reset)
      (req_fire && stat.win_zero) |=> rsp_valid_ff)
      else $error("zero window sample gave no result word");

   // the sample closing a window starts the computation
   a_window_close: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !stat.win_zero && stat.win_last) |=> (state_ff == ST_MUL_LO))
      else $error("window close did not start the computation");

endmodule

// ===== hw/rtl/acrms_dp.sv =====
// ----------------------------------------------------------------------------
// acrms_dp
// datapath of the meter: configuration registers, running sums, split
// products, a shared radix-2 divider, a digit-by-digit square root and the
// result word register
// ----------------------------------------------------------------------------
module acrms_dp
   import acrms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  acrms_cmd_type         cmd,
   output acrms_status_type      stat,
   input  logic [SAMPLE_BITS-1:0] req_sample_mv,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [RMS_W-1:0]      rsp_rms_mv,
   output logic [CUR_W-1:0]      rsp_current_ma
);

   // configuration
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // running sums
   logic [WIN_W-1:0] samples_ff, samples_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  square_ff, square_in;

   // products
   logic [PLO_W-1:0]  prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0] den_ff, den_in;
   logic [NN_W-1:0]   nn_ff, nn_in;

   // shared divider
   logic [PROD_W-1:0] div_q_ff, div_q_in;
   logic [NN_W-1:0]   div_rem_ff, div_rem_in;
   logic [NN_W-1:0]   div_den_ff, div_den_in;

   // square root
   logic [PROD_W-1:0]     root_val_ff, root_val_in;
   logic [ROOT_REM_W-1:0] root_rem_ff, root_rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   // scaled result and step counter
   logic [RMS_W-1:0]  rms_ff, rms_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   // result word
   logic [RMS_W-1:0] out_rms_ff, out_rms_in;
   logic [CUR_W-1:0] out_cur_ff, out_cur_in;

   // combinational helpers
   logic [WIN_W-1:0]      win_eff;
   logic [WIN_W-1:0]      samples_inc;
   logic [PLO_W-1:0]      mul_lo_w;
   logic [PHI_W-1:0]      mul_hi_w;
   logic [PROD_W-1:0]     var_diff;
   logic [NN_W:0]         div_shift;
   logic                  div_ge;
   logic [ROOT_REM_W+1:0] root_next;
   logic [ROOT_REM_W+1:0] root_trial;
   logic                  root_ge;
   logic [RMS_W-1:0]      rms_clamp;
   logic [CUR_W-1:0]      cur_scaled;

   // effective window and status to the controller
   assign win_eff     = (window_ff > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_ff;
   assign samples_inc = samples_ff + 1'b1;

   assign stat.win_zero  = (window_ff == '0);
   assign stat.win_last  = (samples_inc >= win_eff);
   assign stat.gain_zero = (gain_ff == '0);
   assign stat.step_last = (cnt_ff == '0);

   // n times the sum of squares, split at bit 32 of the sum
   assign mul_lo_w = PLO_W'(samples_ff) * PLO_W'(square_ff[QLO_W-1:0]);
   assign mul_hi_w = PHI_W'(samples_ff) * PHI_W'(square_ff[SQ_W-1:QLO_W]);

   // numerator of the variance, floored at zero
   assign var_diff = (num_ff > den_ff) ? (num_ff - den_ff) : '0;

   // one restoring divide step
   assign div_shift = {div_rem_ff, div_q_ff[PROD_W-1]};
   assign div_ge    = (div_shift >= {1'b0, div_den_ff});

   // one square root step, two radicand bits at a time
   assign root_next  = {root_rem_ff, root_val_ff[PROD_W-1:PROD_W-2]};
   assign root_trial = {2'b00, root_ff, 2'b01};
   assign root_ge    = (root_next >= root_trial);

   // clamp and scale to milliamps before the gain divide
   assign rms_clamp  = (root_ff > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_ff[RMS_W-1:0];
   assign cur_scaled = CUR_W'(rms_clamp) * CUR_W'(MA_PER_A);

   // configuration writes
   always_comb begin
      window_in = window_ff;
      gain_in   = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: window_in = csr_data[WIN_W-1:0];
            CSR_MV_PER_AMP:    gain_in   = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // running sums
   always_comb begin
      samples_in = samples_ff;
      sum_in     = sum_ff;
      square_in  = square_ff;
      if (cmd.clear) begin
         samples_in = '0;
         sum_in     = '0;
         square_in  = '0;
      end else if (cmd.accum) begin
         samples_in = samples_inc;
         sum_in     = sum_ff + SUM_W'(req_sample_mv);
         square_in  = square_ff + SQ_W'(req_sample_mv) * SQ_W'(req_sample_mv);
      end
   end

   // products of the window close
   always_comb begin
      prod_lo_in = prod_lo_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      nn_in      = nn_ff;
      if (cmd.mul_lo) begin
         prod_lo_in = mul_lo_w;
         den_in     = PROD_W'(sum_ff) * PROD_W'(sum_ff);
         nn_in      = NN_W'(samples_ff) * NN_W'(samples_ff);
      end
      if (cmd.mul_hi) begin
         num_in = PROD_W'(prod_lo_ff) + {mul_hi_w, {QLO_W{1'b0}}};
      end
   end

   // shared divider and step counter
   always_comb begin
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      cnt_in     = cnt_ff;
      rms_in     = rms_ff;
      if (cmd.var_load) begin
         div_q_in   = var_diff;
         div_rem_in = '0;
         div_den_in = nn_ff;
         cnt_in     = STEP_W'(DIV_STEPS - 1);
      end else if (cmd.scale_load) begin
         // dividend sits at the top so only the current width is walked
         div_q_in   = {cur_scaled, {(PROD_W - CUR_W){1'b0}}};
         div_rem_in = '0;
         div_den_in = NN_W'(gain_ff);
         cnt_in     = STEP_W'(CDIV_STEPS - 1);
         rms_in     = rms_clamp;
      end else if (cmd.root_load) begin
         cnt_in = STEP_W'(ROOT_STEPS - 1);
      end else if (cmd.div_step) begin
         div_q_in   = {div_q_ff[PROD_W-2:0], div_ge};
         div_rem_in = div_ge ? NN_W'(div_shift - {1'b0, div_den_ff}) : div_shift[NN_W-1:0];
         cnt_in     = cnt_ff - 1'b1;
      end else if (cmd.root_step) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // square root unit
   always_comb begin
      root_val_in = root_val_ff;
      root_rem_in = root_rem_ff;
      root_in     = root_ff;
      if (cmd.root_load) begin
         root_val_in = div_q_ff;
         root_rem_in = '0;
         root_in     = '0;
      end else if (cmd.root_step) begin
         root_val_in = {root_val_ff[PROD_W-3:0], 2'b00};
         root_rem_in = root_ge ? ROOT_REM_W'(root_next - root_trial)
                               : root_next[ROOT_REM_W-1:0];
         root_in     = {root_ff[ROOT_W-2:0], root_ge};
      end
   end

   // result word
   always_comb begin
      out_rms_in = out_rms_ff;
      out_cur_in = out_cur_ff;
      if (cmd.zero_out) begin
         out_rms_in = '0;
         out_cur_in = '0;
      end else if (cmd.out_load) begin
         out_rms_in = rms_ff;
         out_cur_in = stat.gain_zero ? '0 : div_q_ff[CUR_W-1:0];
      end
   end

   assign rsp_rms_mv     = out_rms_ff;
   assign rsp_current_ma = out_cur_ff;

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         gain_ff    <= '0;
         samples_ff <= '0;
         sum_ff     <= '0;
         square_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         window_ff  <= window_in;
         gain_ff    <= gain_in;
         samples_ff <= samples_in;
         sum_ff     <= sum_in;
         square_ff  <= square_in;
         cnt_ff     <= cnt_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      prod_lo_ff  <= prod_lo_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      nn_ff       <= nn_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      root_val_ff <= root_val_in;
      root_rem_ff <= root_rem_in;
      root_ff     <= root_in;
      rms_ff      <= rms_in;
      out_rms_ff  <= out_rms_in;
      out_cur_ff  <= out_cur_in;
   end

   // n times the sum of squares never falls below the squared sum
   a_var_nonneg: assert property (@(posedge clock) disable iff (reset)
      cmd.var_load |-> (num_ff >= den_ff))
      else $error("split product gave a negative variance numerator");

   // divider partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (div_rem_ff < div_den_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/ac_rms_current_meter.sv =====
// ----------------------------------------------------------------------------
// ac_rms_current_meter
// ac rms voltage and current of a window of millivolt samples
// ----------------------------------------------------------------------------
// A sample word that does not close the window is accumulated into the
// running sums. The sample that closes it starts the end-of-window
// computation, during which no sample is taken. The computation is two
// split multiplies, then a load and 58 steps of the shared radix-2 divider
// for the variance, then a load and 29 steps of the square root, then a
// scale step and 25 more divider steps for the current (skipped at zero
// gain), and last an output step. The output step loads the result word,
// and holds while an earlier word is still waiting to be taken. Sampling
// resumes in the cycle after the load. With a zero window every sample
// gives a zero result word in the next cycle, once the previous word has
// been taken. Configuration writes are taken every cycle and do not clear
// the running sums.
module ac_rms_current_meter
   import acrms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_mv,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RMS_W-1:0]       rsp_rms_mv,
   output logic [CUR_W-1:0]       rsp_current_ma,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   acrms_cmd_type    cmd;
   acrms_status_type stat;

   // configuration is always writable
   assign csr_ready = 1'b1;

   // sequencer
   acrms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   acrms_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_sample_mv  (req_sample_mv),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_rms_mv     (rsp_rms_mv),
      .rsp_current_ma (rsp_current_ma)
   );

endmodule

// ===== sim/ac_rms_current_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_current_meter_checker
// watches the sample, result and register channels of the rms meter, keeps
// its own copy of the window sums and registers, predicts every result word
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module ac_rms_current_meter_checker
   import acrms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_mv,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [RMS_W-1:0]       rsp_rms_mv,
   input  logic [CUR_W-1:0]       rsp_current_ma,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     words_pending,
   output int                     mismatch_count
);

   typedef struct packed {
      logic [RMS_W-1:0] rms_mv;
      logic [CUR_W-1:0] current_ma;
   } meter_word_type;

   // predicted result words, oldest first
   meter_word_type expected_words[$];

   // shadow registers and window sums
   logic [WIN_W-1:0]  window_length = WINDOW_RESET;
   logic [GAIN_W-1:0] mv_per_amp    = '0;
   logic [WIN_W-1:0]  samples_seen  = '0;
   logic [SUM_W-1:0]  sample_sum    = '0;
   logic [SQ_W-1:0]   square_sum    = '0;
   int                fail_total    = 0;

   always @(posedge clock) begin : track
      logic [WIN_W-1:0] span;
      logic [63:0]      x, n, num, den, variance, trial, amps;
      logic [31:0]      root;
      meter_word_type   want;

      if (reset) begin
         window_length = WINDOW_RESET;
         mv_per_amp    = '0;
         samples_seen  = '0;
         sample_sum    = '0;
         square_sum    = '0;
         expected_words.delete();
      end else begin
         // result word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t window check: result word with none expected, rms_mv %0d current_ma %0d",
                        $time, rsp_rms_mv, rsp_current_ma);
               fail_total++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_rms_mv !== want.rms_mv) begin
                  $display("%0t window check: rms_mv expected %0d actual %0d",
                           $time, want.rms_mv, rsp_rms_mv);
                  fail_total++;
               end
               if (rsp_current_ma !== want.current_ma) begin
                  $display("%0t window check: current_ma expected %0d actual %0d",
                           $time, want.current_ma, rsp_current_ma);
                  fail_total++;
               end
            end
         end

         // register writes, unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: window_length = csr_data[WIN_W-1:0];
               CSR_MV_PER_AMP:    mv_per_amp    = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end

         // sample word: accumulate, close the window when it is full
         if (req_valid && req_ready) begin
            span = (window_length > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : window_length;
            if (span == '0) begin
               // zero window gives a zero word and keeps the sums empty
               samples_seen = '0;
               sample_sum   = '0;
               square_sum   = '0;
               expected_words.push_back('0);
            end else begin
               x            = 64'(req_sample_mv);
               samples_seen = samples_seen + 1'b1;
               sample_sum   = sample_sum + SUM_W'(x);
               square_sum   = square_sum + SQ_W'(x * x);
               if (samples_seen >= span) begin
                  // population variance (n*Q - S*S) / n^2, then floor root
                  n        = 64'(samples_seen);
                  num      = n * 64'(square_sum);
                  den      = 64'(sample_sum) * 64'(sample_sum);
                  variance = (num > den) ? (num - den) / (n * n) : 64'd0;
                  root     = '0;
                  for (int b = 31; b >= 0; b--) begin
                     trial = 64'(root | (32'd1 << b));
                     if (trial * trial <= variance)
                        root = root | (32'd1 << b);
                  end
                  if (root > 32'(RMS_MAX))
                     root = 32'(RMS_MAX);
                  amps = (mv_per_amp == '0) ? 64'd0
                                            : (64'(root) * 64'(MA_PER_A)) / 64'(mv_per_amp);
                  want.rms_mv     = root[RMS_W-1:0];
                  want.current_ma = amps[CUR_W-1:0];
                  expected_words.push_back(want);
                  samples_seen = '0;
                  sample_sum   = '0;
                  square_sum   = '0;
               end
            end
         end
      end

      words_pending  <= expected_words.size();
      mismatch_count <= fail_total;
   end

endmodule

// ===== sim/ac_rms_current_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_rms_current_meter_tb
// drives sample words and register writes into the rms meter under several
// idling patterns: a directed part for the special cases, random windows and
// gains with shaped sample data, then an oversized window setting; the
// window checker predicts and compares every result word
// ----------------------------------------------------------------------------
module ac_rms_current_meter_tb;
   import acrms_pkg::*;

   localparam int RANDOM_ITEMS   = 460;
   // leave margin after the end-of-window math before writes
   localparam int SETTLE_CYCLES  = 160;
   // longest quiet stretch: window math plus a long receiver stall
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_mode_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample_mv  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [RMS_W-1:0]       rsp_rms_mv;
   logic [CUR_W-1:0]       rsp_current_ma;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   int words_pending;
   int mismatch_count;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   always #6 clock = ~clock;

   ac_rms_current_meter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_mv  (req_sample_mv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rms_mv     (rsp_rms_mv),
      .rsp_current_ma (rsp_current_ma),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   ac_rms_current_meter_checker window_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_mv  (req_sample_mv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rms_mv     (rsp_rms_mv),
      .rsp_current_ma (rsp_current_ma),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .words_pending  (words_pending),
      .mismatch_count (mismatch_count)
   );

   // result side backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling(input idling_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
         IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct <= 74; end
         default:       begin send_idle_pct = 9;  recv_stall_pct <= 9;  end
      endcase
   endtask

   // one sample word, with a random gap in front; valid stays up afterwards
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_mv <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, then a write to an unused index that must be dropped
   task automatic write_config(input logic [CSR_DATA_W-1:0] window_data,
                               input logic [CSR_DATA_W-1:0] gain_data);
      csr_valid <= 1'b1;
      csr_index <= CSR_WINDOW_LENGTH;
      csr_data  <= window_data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MV_PER_AMP;
      csr_data  <= gain_data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_IDX_W'($urandom_range(15, 2));
      csr_data  <= CSR_DATA_W'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int                     phase;
      int                     done_items;
      int                     batch;
      int                     style;
      int                     pick;
      int                     spread;
      logic [CSR_DATA_W-1:0]  win_data;
      logic [CSR_DATA_W-1:0]  gain_data;
      logic [SAMPLE_BITS-1:0] level_lo;
      logic [SAMPLE_BITS-1:0] level_hi;
      logic [SAMPLE_BITS-1:0] sample;

      set_idling(IDLE_NONE);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window is long: three samples leave it open, then shrink it
      send_sample('0);
      send_sample('1);
      send_sample(SAMPLE_BITS'(1234));
      drain_results();
      write_config(CSR_DATA_W'(3), '0);
      send_sample(SAMPLE_BITS'(40000));
      drain_results();

      // single sample windows, largest gain
      write_config(CSR_DATA_W'(1), '1);
      send_sample('0);
      send_sample('1);
      drain_results();

      // full swing gives the largest rms and, at unit gain, current
      write_config(CSR_DATA_W'(2), CSR_DATA_W'(1));
      send_sample('0);
      send_sample('1);
      send_sample('1);
      send_sample('1);
      drain_results();

      // zero window in the middle of a window drops the partial sums
      write_config(CSR_DATA_W'(5), CSR_DATA_W'(1000));
      send_sample(SAMPLE_BITS'(100));
      send_sample(SAMPLE_BITS'(200));
      drain_results();
      write_config('0, CSR_DATA_W'(1000));
      send_sample(SAMPLE_BITS'(300));
      send_sample(SAMPLE_BITS'(400));
      drain_results();
      write_config(CSR_DATA_W'(2), CSR_DATA_W'(1000));
      send_sample(SAMPLE_BITS'(500));
      send_sample(SAMPLE_BITS'(900));
      drain_results();

      // random windows and gains, partial windows carry across phases
      phase      = 0;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         set_idling(idling_mode_type'(phase % 4));
         pick = $urandom_range(99);
         if (pick < 8)
            win_data = '0;
         else if (pick < 80)
            win_data = CSR_DATA_W'($urandom_range(12, 1));
         else if (pick < 95)
            win_data = CSR_DATA_W'($urandom_range(64, 13));
         else
            win_data = CSR_DATA_W'($urandom_range(400, 65));
         pick = $urandom_range(99);
         if (pick < 15)
            gain_data = '0;
         else if (pick < 25)
            gain_data = CSR_DATA_W'(1);
         else if (pick < 35)
            gain_data = '1;
         else
            gain_data = CSR_DATA_W'($urandom);
         write_config(win_data, gain_data);

         batch    = $urandom_range(60, 20);
         style    = $urandom_range(3);
         level_lo = SAMPLE_BITS'($urandom_range(60000));
         level_hi = SAMPLE_BITS'($urandom);
         spread   = $urandom_range(5000, 1);
         for (int i = 0; i < batch; i++) begin
            case (style)
               0:       sample = SAMPLE_BITS'($urandom);
               1:       sample = level_lo + SAMPLE_BITS'($urandom_range(spread));
               2:       sample = i[0] ? level_hi : level_lo;
               default: sample = $urandom_range(1) ? '1 : '0;
            endcase
            send_sample(sample);
            done_items++;
         end
         drain_results();
         phase++;
      end

      // oversized window setting is held at the maximum: a short run stays
      // open, then a small window closes it with every sample taken
      set_idling(IDLE_NONE);
      write_config('1, '1);
      for (int i = 0; i < 24; i++)
         send_sample(i[0] ? '1 : SAMPLE_BITS'($urandom));
      drain_results();
      write_config(CSR_DATA_W'(2), CSR_DATA_W'(1));
      send_sample('1);
      drain_results();

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
